/* design/adsr_pkg.sv */
package adsr_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int LEVEL_W = FRACTION_BITS + 1;

  localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << FRACTION_BITS;
  localparam logic [LEVEL_W-1:0] RATE_RESET = LEVEL_W'(699);

  typedef enum logic [1:0] {
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK_STEP,
    REG_DECAY_RATE,
    REG_SUSTAIN_LEVEL,
    REG_RELEASE_RATE
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] attack_step;
    logic [LEVEL_W-1:0] decay_step;
    logic [LEVEL_W-1:0] sustain_level;
    logic [LEVEL_W-1:0] release_rate;
  } cfg_t;

  function automatic logic [LEVEL_W-1:0] clamp_one(input logic [LEVEL_W-1:0] v);
    return (v > ONE_LEVEL) ? ONE_LEVEL : v;
  endfunction

  // floor(a * b) in fraction units, raised to one unit when that is zero and both factors are nonzero
  function automatic logic [LEVEL_W-1:0] scale_step(input logic [LEVEL_W-1:0] a,
                                                    input logic [LEVEL_W-1:0] b);
    logic [2*LEVEL_W-1:0] prod;
    logic [LEVEL_W-1:0]   r;
    prod = (2*LEVEL_W)'(a) * (2*LEVEL_W)'(b);
    r = prod[FRACTION_BITS +: LEVEL_W];
    if (r == '0 && a != '0 && b != '0) begin
      r = LEVEL_W'(1);
    end
    return r;
  endfunction

endpackage

/* design/adsr_in_if.sv */
interface adsr_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink (input valid, input gate, output ready);
endinterface

/* design/adsr_out_if.sv */
interface adsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [adsr_pkg::LEVEL_W-1:0] level;
  logic [1:0]                   phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink (input valid, input level, input phase, output ready);
endinterface

/* design/adsr_cfg_if.sv */
interface adsr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   index;
  logic [adsr_pkg::LEVEL_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/adsr_cfg.sv */
module adsr_cfg (
  input  logic             clk,
  input  logic             rst,
  adsr_cfg_if.sink         cfg,
  output adsr_pkg::cfg_t   regs
);

  logic [adsr_pkg::LEVEL_W-1:0] attack_step;
  logic [adsr_pkg::LEVEL_W-1:0] decay_rate;
  logic [adsr_pkg::LEVEL_W-1:0] sustain_level;
  logic [adsr_pkg::LEVEL_W-1:0] release_rate;
  logic [adsr_pkg::LEVEL_W-1:0] decay_step;
  logic [adsr_pkg::LEVEL_W-1:0] decay_step_next;
  logic [adsr_pkg::LEVEL_W-1:0] wr_value;
  logic [adsr_pkg::LEVEL_W-1:0] mul_a;
  logic [adsr_pkg::LEVEL_W-1:0] mul_b;
  adsr_pkg::cfg_reg_t           wr_reg;
  logic                         wr_en;

  assign cfg.ready = 1'b1;
  assign wr_en     = cfg.valid && cfg.ready;
  assign wr_reg    = adsr_pkg::cfg_reg_t'(cfg.index);
  assign wr_value  = adsr_pkg::clamp_one(cfg.data);

  // decay step is (1 - sustain) * decay_rate, taken with the value being written
  always_comb begin
    if (wr_reg == adsr_pkg::REG_SUSTAIN_LEVEL) begin
      mul_a = adsr_pkg::ONE_LEVEL - wr_value;
      mul_b = decay_rate;
    end else begin
      mul_a = adsr_pkg::ONE_LEVEL - sustain_level;
      mul_b = wr_value;
    end
    decay_step_next = adsr_pkg::scale_step(mul_a, mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= adsr_pkg::RATE_RESET;
      decay_rate    <= adsr_pkg::RATE_RESET;
      sustain_level <= adsr_pkg::ONE_LEVEL;
      release_rate  <= adsr_pkg::RATE_RESET;
      decay_step    <= '0;
    end else if (wr_en) begin
      unique case (wr_reg)
        adsr_pkg::REG_ATTACK_STEP: begin
          attack_step <= wr_value;
        end
        adsr_pkg::REG_DECAY_RATE: begin
          decay_rate <= wr_value;
          decay_step <= decay_step_next;
        end
        adsr_pkg::REG_SUSTAIN_LEVEL: begin
          sustain_level <= wr_value;
          decay_step    <= decay_step_next;
        end
        adsr_pkg::REG_RELEASE_RATE: begin
          release_rate <= wr_value;
        end
        default: begin
        end
      endcase
    end
  end

  assign regs.attack_step   = attack_step;
  assign regs.decay_step    = decay_step;
  assign regs.sustain_level = sustain_level;
  assign regs.release_rate  = release_rate;

endmodule

/* design/adsr_core.sv */
module adsr_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         gate,
  input  adsr_pkg::cfg_t               regs,
  output logic [adsr_pkg::LEVEL_W-1:0] level,
  output adsr_pkg::phase_t             phase
);

  adsr_pkg::phase_t             current_phase;
  adsr_pkg::phase_t             current_phase_next;
  logic [adsr_pkg::LEVEL_W-1:0] current_level;
  logic [adsr_pkg::LEVEL_W-1:0] current_level_next;
  logic [adsr_pkg::LEVEL_W-1:0] release_decrement;
  logic [adsr_pkg::LEVEL_W-1:0] release_decrement_next;
  logic                         previous_gate;
  adsr_pkg::phase_t             edge_phase;
  logic [adsr_pkg::LEVEL_W-1:0] edge_level;

  always_comb begin
    edge_phase             = current_phase;
    edge_level             = current_level;
    release_decrement_next = release_decrement;
    if (gate && !previous_gate) begin
      edge_phase = adsr_pkg::PH_ATTACK;
      edge_level = '0;
    end else if (!gate && previous_gate) begin
      edge_phase             = adsr_pkg::PH_RELEASE;
      release_decrement_next = adsr_pkg::scale_step(current_level, regs.release_rate);
    end

    current_phase_next = edge_phase;
    current_level_next = edge_level;
    unique case (edge_phase)
      adsr_pkg::PH_ATTACK: begin
        if (edge_level >= adsr_pkg::ONE_LEVEL) begin
          current_phase_next = adsr_pkg::PH_DECAY;
          current_level_next = adsr_pkg::ONE_LEVEL;
        end else if (adsr_pkg::ONE_LEVEL - edge_level <= regs.attack_step) begin
          current_level_next = adsr_pkg::ONE_LEVEL;
        end else begin
          current_level_next = edge_level + regs.attack_step;
        end
      end
      adsr_pkg::PH_DECAY: begin
        if (edge_level <= regs.sustain_level) begin
          current_phase_next = adsr_pkg::PH_SUSTAIN;
          current_level_next = regs.sustain_level;
        end else if (edge_level - regs.sustain_level <= regs.decay_step) begin
          current_level_next = regs.sustain_level;
        end else begin
          current_level_next = edge_level - regs.decay_step;
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
      end
      adsr_pkg::PH_RELEASE: begin
        if (edge_level <= release_decrement_next) begin
          current_level_next = '0;
        end else begin
          current_level_next = edge_level - release_decrement_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_phase     <= adsr_pkg::PH_RELEASE;
      current_level     <= '0;
      release_decrement <= '0;
      previous_gate     <= 1'b0;
    end else if (advance) begin
      current_phase     <= current_phase_next;
      current_level     <= current_level_next;
      release_decrement <= release_decrement_next;
      previous_gate     <= gate;
    end
  end

  assign level = current_level;
  assign phase = current_phase;

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    current_level <= adsr_pkg::ONE_LEVEL)
    else $error("envelope level above full scale");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(current_level) && $stable(current_phase))
    else $error("envelope moved without an accepted beat");

  a_attack_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && gate && !previous_gate) |=>
      current_phase == adsr_pkg::PH_ATTACK && current_level == $past(regs.attack_step))
    else $error("rising gate did not restart attack from zero");

  a_release_falls: assert property (@(posedge clk) disable iff (rst)
    (advance && !gate && current_phase == adsr_pkg::PH_RELEASE) |=>
      current_level <= $past(current_level))
    else $error("level rose during release");

endmodule

/* design/adsr_envelope.sv */
// Linear ADSR envelope generator.
// sample: one beat per sample tick carrying the gate level (1 = key held).
// result: one beat per sample beat carrying the level after that tick
//   (Q1.24, 16777216 = full scale) and the phase (attack, decay, sustain,
//   release).
// cfg: register writes, index 0 attack_step, 1 decay_rate, 2 sustain_level,
//   3 release_rate; data above full scale is clamped. cfg.ready is always high.
//   Write only while no sample beat is in flight.
// Path: an accepted sample beat waits in the input register; when the output
//   is free the core registers its update and out_valid, offering the result.
// Throughput: one sample beat per cycle while result is not held; the envelope update is a single
//   registered pass with one 25x25 multiply on the falling-gate path.
// Reset: the envelope sits silent in release at level zero and registers
//   return to their defaults (rates 699, sustain at full scale).
// Stall: while result is held, the pending result stays put, one further
//   sample beat is taken into the input register and then sample.ready drops.
module adsr_envelope (
  input  logic        clk,
  input  logic        rst,
  adsr_in_if.sink     sample,
  adsr_out_if.source  result,
  adsr_cfg_if.sink    cfg
);

  adsr_pkg::cfg_t               regs;
  logic                         in_valid;
  logic                         in_gate;
  logic                         out_valid;
  logic                         advance;
  logic [adsr_pkg::LEVEL_W-1:0] level;
  adsr_pkg::phase_t             phase;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sample.ready) begin
        in_valid <= sample.valid;
      end
      out_valid <= advance || (out_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_gate <= sample.gate;
    end
  end

  adsr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  adsr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .gate    (in_gate),
    .regs    (regs),
    .level   (level),
    .phase   (phase)
  );

  assign result.valid = out_valid;
  assign result.level = level;
  assign result.phase = 2'(phase);

endmodule
